// ----- sv/thcap_pkg.sv -----
// shared types, constants and lookup functions of the thermal level frequency capper
package thcap_pkg;

   // field widths
   localparam int TEMP_W      = 19;
   localparam int HYST_W      = 17;
   localparam int CPU_FREQ_W  = 22;
   localparam int TBL_VAL_W   = 32;
   localparam int TBL_IDX_W   = 4;
   localparam int TBL_SEL_W   = 2;
   localparam int LVL_W       = 3;
   localparam int PCT_W       = 7;
   localparam int PROD_W      = TBL_VAL_W + PCT_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 22;
   localparam int NUM_TABLES  = 3;

   // default table depth
   localparam int TABLE_DEPTH_DEF = 16;

   // operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // table select codes
   localparam logic [TBL_SEL_W-1:0] TBL_GPU    = 2'd0;
   localparam logic [TBL_SEL_W-1:0] TBL_GPU_BW = 2'd1;
   localparam logic [TBL_SEL_W-1:0] TBL_DDR    = 2'd2;
   localparam logic [TBL_SEL_W-1:0] TBL_NONE   = 2'd3;

   // throttle levels
   localparam logic [LVL_W-1:0] LVL_NONE     = 3'd0;
   localparam logic [LVL_W-1:0] LVL_ONE      = 3'd1;
   localparam logic [LVL_W-1:0] LVL_TWO      = 3'd2;
   localparam logic [LVL_W-1:0] LVL_THREE    = 3'd3;
   localparam logic [LVL_W-1:0] LVL_EMERG    = 3'd4;
   localparam logic [LVL_W-1:0] LVL_UNKNOWN  = 3'd7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL1_THR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL2_THR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL3_THR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL4_THR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LITTLE_MAX = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_MAX    = 3'd6;

   // register reset values
   localparam logic signed [TEMP_W-1:0] LEVEL1_THR_RST = 19'sd45000;
   localparam logic signed [TEMP_W-1:0] LEVEL2_THR_RST = 19'sd50000;
   localparam logic signed [TEMP_W-1:0] LEVEL3_THR_RST = 19'sd55000;
   localparam logic signed [TEMP_W-1:0] LEVEL4_THR_RST = 19'sd60000;
   localparam logic [HYST_W-1:0]        HYSTERESIS_RST = 17'd3000;
   localparam logic [CPU_FREQ_W-1:0]    LITTLE_MAX_RST = 22'd1843200;
   localparam logic [CPU_FREQ_W-1:0]    BIG_MAX_RST    = 22'd2208000;

   // controller to datapath commands
   typedef struct packed {
      logic sample;
      logic write;
      logic prep;
      logic scan_step;
      logic load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic changed;
      logic scan_last;
   } stat_type;

   // one result item
   typedef struct packed {
      logic [LVL_W-1:0]      level;
      logic [CPU_FREQ_W-1:0] little_cpu_cap;
      logic [CPU_FREQ_W-1:0] big_cpu_cap;
      logic [TBL_VAL_W-1:0]  gpu_cap;
      logic                  gpu_cap_valid;
      logic [TBL_VAL_W-1:0]  gpu_bw_cap;
      logic                  gpu_bw_cap_valid;
      logic [TBL_VAL_W-1:0]  ddr_cap;
      logic                  ddr_cap_valid;
   } result_type;

   // little cluster cap of a throttled level
   function automatic logic [CPU_FREQ_W-1:0] little_cap_of(input logic [LVL_W-1:0] lvl);
      logic [CPU_FREQ_W-1:0] cap;
      case (lvl)
         LVL_ONE:   cap = 22'd1401600;
         LVL_TWO:   cap = 22'd1113600;
         LVL_THREE: cap = 22'd998400;
         LVL_EMERG: cap = 22'd806400;
         default:   cap = '0;
      endcase
      return cap;
   endfunction

   // big cluster cap of a throttled level
   function automatic logic [CPU_FREQ_W-1:0] big_cap_of(input logic [LVL_W-1:0] lvl);
      logic [CPU_FREQ_W-1:0] cap;
      case (lvl)
         LVL_ONE:   cap = 22'd1804800;
         LVL_TWO:   cap = 22'd1401600;
         LVL_THREE: cap = 22'd1113600;
         LVL_EMERG: cap = 22'd902400;
         default:   cap = '0;
      endcase
      return cap;
   endfunction

   // percent of the table maximum allowed at a level
   function automatic logic [PCT_W-1:0] pct_of(input logic [LVL_W-1:0] lvl,
                                              input logic [TBL_SEL_W-1:0] sel);
      logic [PCT_W-1:0] pct;
      case (lvl)
         LVL_ONE:   pct = (sel == TBL_DDR) ? 7'd80 : 7'd85;
         LVL_TWO:   pct = (sel == TBL_DDR) ? 7'd65 : 7'd70;
         LVL_THREE: pct = (sel == TBL_DDR) ? 7'd50 : 7'd55;
         LVL_EMERG: pct = 7'd40;
         default:   pct = 7'd100;
      endcase
      return pct;
   endfunction

endpackage

// ----- sv/thcap_if.sv -----
// channel interfaces: request items, result items and register writes

interface thcap_req_if;
   import thcap_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic signed [TEMP_W-1:0]     temperature;
   logic [TBL_SEL_W-1:0]         table_select;
   logic [TBL_IDX_W-1:0]         table_index;
   logic [TBL_VAL_W-1:0]         table_value;

   modport source (output valid, operation, temperature, table_select, table_index,
                   table_value, input ready);
   modport sink   (input valid, operation, temperature, table_select, table_index,
                   table_value, output ready);
endinterface

interface thcap_rsp_if;
   import thcap_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [LVL_W-1:0]      level;
   logic [CPU_FREQ_W-1:0] little_cpu_cap;
   logic [CPU_FREQ_W-1:0] big_cpu_cap;
   logic [TBL_VAL_W-1:0]  gpu_cap;
   logic                  gpu_cap_valid;
   logic [TBL_VAL_W-1:0]  gpu_bw_cap;
   logic                  gpu_bw_cap_valid;
   logic [TBL_VAL_W-1:0]  ddr_cap;
   logic                  ddr_cap_valid;

   modport source (output valid, level, little_cpu_cap, big_cpu_cap, gpu_cap, gpu_cap_valid,
                   gpu_bw_cap, gpu_bw_cap_valid, ddr_cap, ddr_cap_valid, input ready);
   modport sink   (input valid, level, little_cpu_cap, big_cpu_cap, gpu_cap, gpu_cap_valid,
                   gpu_bw_cap, gpu_bw_cap_valid, ddr_cap, ddr_cap_valid, output ready);
endinterface

interface thcap_csr_if;
   import thcap_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/thcap_ctrl.sv -----
// controller state machine: sequences level decision, table scan and result transfer
module thcap_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output thcap_pkg::cmd_type  cmd,
   input  thcap_pkg::stat_type stat
);
   import thcap_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // commands decoded from state
   always_comb begin
      cmd           = '0;
      cmd.sample    = (state_ff == ST_IDLE) && req_valid && (req_operation == OP_SAMPLE);
      cmd.write     = (state_ff == ST_IDLE) && req_valid && (req_operation == OP_WRITE);
      cmd.prep      = (state_ff == ST_PREP);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.load      = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (cmd.sample) state_in = ST_LEVEL;
         ST_LEVEL: state_in = stat.changed ? ST_PREP : ST_IDLE;
         ST_PREP:  state_in = ST_SCAN;
         ST_SCAN:  if (stat.scan_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_FIN;
         ST_FIN:   if (cmd.load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // output register valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/thcap_dp.sv -----
// datapath: registers, level quantizer, frequency tables and cap selection
module thcap_dp #(
   parameter int TABLE_DEPTH = thcap_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  thcap_pkg::cmd_type                     cmd,
   output thcap_pkg::stat_type                    stat,
   input  logic signed [thcap_pkg::TEMP_W-1:0]    req_temperature,
   input  logic [thcap_pkg::TBL_SEL_W-1:0]        req_table_select,
   input  logic [thcap_pkg::TBL_IDX_W-1:0]        req_table_index,
   input  logic [thcap_pkg::TBL_VAL_W-1:0]        req_table_value,
   input  logic                                   csr_write,
   input  logic [thcap_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [thcap_pkg::CSR_DATA_W-1:0]       csr_data,
   output thcap_pkg::result_type                  result
);
   import thcap_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // configuration registers
   logic signed [TEMP_W-1:0] thr1_ff, thr2_ff, thr3_ff, thr4_ff;
   logic [HYST_W-1:0]        hyst_ff;
   logic [CPU_FREQ_W-1:0]    little_max_ff, big_max_ff;

   // level state
   logic [LVL_W-1:0] prev_ff;
   logic [LVL_W-1:0] lvl_ff;
   logic             changed_ff;
   logic [LVL_W-1:0] raw_lvl, lvl_in;
   logic signed [TEMP_W-1:0] prev_thr;
   logic signed [TEMP_W:0]   cool;
   logic signed [TEMP_W:0]   temp_ext;

   // scan control
   logic [ADDR_W-1:0] scan_ptr_ff;
   logic [ADDR_W-1:0] scan_idx_ff;
   logic              scan_vld_ff;
   logic              idx_ok;

   // per-table caps
   logic [TBL_VAL_W-1:0] tcap [NUM_TABLES];
   logic                 tok  [NUM_TABLES];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr1_ff       <= LEVEL1_THR_RST;
         thr2_ff       <= LEVEL2_THR_RST;
         thr3_ff       <= LEVEL3_THR_RST;
         thr4_ff       <= LEVEL4_THR_RST;
         hyst_ff       <= HYSTERESIS_RST;
         little_max_ff <= LITTLE_MAX_RST;
         big_max_ff    <= BIG_MAX_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LEVEL1_THR: thr1_ff       <= csr_data[TEMP_W-1:0];
            CSR_LEVEL2_THR: thr2_ff       <= csr_data[TEMP_W-1:0];
            CSR_LEVEL3_THR: thr3_ff       <= csr_data[TEMP_W-1:0];
            CSR_LEVEL4_THR: thr4_ff       <= csr_data[TEMP_W-1:0];
            CSR_HYSTERESIS: hyst_ff       <= csr_data[HYST_W-1:0];
            CSR_LITTLE_MAX: little_max_ff <= csr_data[CPU_FREQ_W-1:0];
            CSR_BIG_MAX:    big_max_ff    <= csr_data[CPU_FREQ_W-1:0];
            default:        ;
         endcase
      end
   end

   // threshold quantizer, highest level first
   always_comb begin
      if (req_temperature >= thr4_ff) begin
         raw_lvl = LVL_EMERG;
      end else if (req_temperature >= thr3_ff) begin
         raw_lvl = LVL_THREE;
      end else if (req_temperature >= thr2_ff) begin
         raw_lvl = LVL_TWO;
      end else if (req_temperature >= thr1_ff) begin
         raw_lvl = LVL_ONE;
      end else begin
         raw_lvl = LVL_NONE;
      end
   end

   // hysteresis against the previous level's threshold
   always_comb begin
      case (prev_ff)
         LVL_ONE:   prev_thr = thr1_ff;
         LVL_TWO:   prev_thr = thr2_ff;
         LVL_THREE: prev_thr = thr3_ff;
         default:   prev_thr = thr4_ff;
      endcase
      temp_ext = {req_temperature[TEMP_W-1], req_temperature};
      cool     = {prev_thr[TEMP_W-1], prev_thr} - signed'({3'b000, hyst_ff});
      lvl_in   = raw_lvl;
      if ((prev_ff >= LVL_ONE) && (prev_ff <= LVL_EMERG) && (raw_lvl < prev_ff)
          && (temp_ext > cool)) begin
         lvl_in = prev_ff;
      end
   end

   // level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= LVL_UNKNOWN;
         changed_ff <= 1'b0;
      end else if (cmd.sample) begin
         prev_ff    <= lvl_in;
         changed_ff <= (lvl_in != prev_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample) begin
         lvl_ff <= lvl_in;
      end
   end

   // scan address counter and delayed read tag
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_step;
         if (cmd.prep) begin
            scan_ptr_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_ptr_ff <= scan_ptr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_ptr_ff;
   end

   assign stat.changed   = changed_ff;
   assign stat.scan_last = (scan_ptr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign idx_ok         = (int'(req_table_index) < TABLE_DEPTH);

   // one table per lane: memory, count, maximum and scan trackers
   for (genvar s = 0; s < NUM_TABLES; s++) begin : g_tbl
      logic [TBL_VAL_W-1:0] mem [TABLE_DEPTH];
      logic [TBL_VAL_W-1:0] rd_ff;
      logic [TBL_VAL_W-1:0] max_ff;
      logic [CNT_W-1:0]     count_ff;
      logic [PROD_W-1:0]    prod_ff;
      logic [TBL_VAL_W-1:0] best_ff;
      logic [TBL_VAL_W-1:0] min_ff;
      logic                 we;
      logic [PROD_W-1:0]    scaled;
      logic                 in_range;
      logic [TBL_VAL_W-1:0] cap;

      assign we = cmd.write && idx_ok && (req_table_select == TBL_SEL_W'(s))
                  && (req_table_select != TBL_NONE);

      // table memory: one write port, one registered read port
      always_ff @(posedge clock) begin
         if (we) begin
            mem[ADDR_W'(req_table_index)] <= req_table_value;
         end
         if (cmd.scan_step) begin
            rd_ff <= mem[scan_ptr_ff];
         end
      end

      // count and running maximum
      always_ff @(posedge clock) begin
         if (reset) begin
            max_ff   <= '0;
            count_ff <= '0;
         end else if (we) begin
            count_ff <= CNT_W'(req_table_index) + CNT_W'(1);
            if ((req_table_index == '0) || (req_table_value > max_ff)) begin
               max_ff <= req_table_value;
            end
         end
      end

      // entry times 100 compared against maximum times percent
      assign scaled   = PROD_W'({rd_ff, 6'b0}) + PROD_W'({rd_ff, 5'b0})
                      + PROD_W'({rd_ff, 2'b0});
      assign in_range = scan_vld_ff && (CNT_W'(scan_idx_ff) < count_ff);

      // target product, best qualifying entry and smallest entry
      always_ff @(posedge clock) begin
         if (cmd.prep) begin
            prod_ff <= PROD_W'(max_ff) * PROD_W'(pct_of(lvl_ff, TBL_SEL_W'(s)));
            best_ff <= '0;
         end else if (in_range) begin
            if ((scaled <= prod_ff) && (rd_ff >= best_ff)) begin
               best_ff <= rd_ff;
            end
            if ((scan_idx_ff == '0) || (rd_ff < min_ff)) begin
               min_ff <= rd_ff;
            end
         end
      end

      // final cap and its valid flag
      assign cap     = (lvl_ff == LVL_NONE) ? max_ff : ((best_ff != '0) ? best_ff : min_ff);
      assign tok[s]  = (count_ff != '0) && (cap != '0);
      assign tcap[s] = tok[s] ? cap : '0;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         result.level            <= lvl_ff;
         result.little_cpu_cap   <= (lvl_ff == LVL_NONE) ? little_max_ff
                                                         : little_cap_of(lvl_ff);
         result.big_cpu_cap      <= (lvl_ff == LVL_NONE) ? big_max_ff : big_cap_of(lvl_ff);
         result.gpu_cap          <= tcap[TBL_GPU];
         result.gpu_cap_valid    <= tok[TBL_GPU];
         result.gpu_bw_cap       <= tcap[TBL_GPU_BW];
         result.gpu_bw_cap_valid <= tok[TBL_GPU_BW];
         result.ddr_cap          <= tcap[TBL_DDR];
         result.ddr_cap_valid    <= tok[TBL_DDR];
      end
   end

endmodule

// ----- sv/thermal_level_freq_capper.sv -----
// top level of the thermal level frequency capper
//
// req_ch takes two kinds of items. A table write (operation 1) stores one entry
// of the GPU, GPU bandwidth or DDR table in its accept cycle; index 0 restarts a
// table. A temperature sample (operation 0) is quantized into levels 0 to 4 with
// hysteresis on the way down. Only a sample that changes the level gives a result
// on rsp_ch: the level, both CPU cluster caps and the three table caps.
// csr_ch writes the thresholds, hysteresis and CPU maxima; it is always ready.
// A sample with a change scans all three tables in parallel, one entry per cycle
// through each table memory's single read port, before the result is loaded
// into the output register; a table write and a sample with no change skip the scan.
// One item is worked on at a time; req_ch.ready is high only when idle.
// A stalled result holds in the output register while req_ch keeps taking
// items; a second result waits in its final step until the register frees.
// Reset restores the register defaults, empties all tables and forgets the
// previous level, so the first sample always gives a result.
module thermal_level_freq_capper #(
   parameter int TABLE_DEPTH = thcap_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   thcap_req_if.sink   req_ch,
   thcap_rsp_if.source rsp_ch,
   thcap_csr_if.sink   csr_ch
);
   import thcap_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   result_type result;
   logic       req_ready;
   logic       rsp_valid;

   // controller
   thcap_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ready),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd),
      .stat          (stat)
   );

   // datapath
   thcap_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_temperature  (req_ch.temperature),
      .req_table_select (req_ch.table_select),
      .req_table_index  (req_ch.table_index),
      .req_table_value  (req_ch.table_value),
      .csr_write        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .result           (result)
   );

   // channel hookup
   assign req_ch.ready            = req_ready;
   assign csr_ch.ready            = 1'b1;
   assign rsp_ch.valid            = rsp_valid;
   assign rsp_ch.level            = result.level;
   assign rsp_ch.little_cpu_cap   = result.little_cpu_cap;
   assign rsp_ch.big_cpu_cap      = result.big_cpu_cap;
   assign rsp_ch.gpu_cap          = result.gpu_cap;
   assign rsp_ch.gpu_cap_valid    = result.gpu_cap_valid;
   assign rsp_ch.gpu_bw_cap       = result.gpu_bw_cap;
   assign rsp_ch.gpu_bw_cap_valid = result.gpu_bw_cap_valid;
   assign rsp_ch.ddr_cap          = result.ddr_cap;
   assign rsp_ch.ddr_cap_valid    = result.ddr_cap_valid;

   // a sample transfer always occupies the block for the level decision
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.operation == OP_SAMPLE)) |=> !req_ch.ready)
      else $error("request taken right after a sample");

   // a reported level never exceeds emergency
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.level <= LVL_EMERG))
      else $error("result level out of range");

   // cap valid flags agree with nonzero caps
   a_cap_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.gpu_cap_valid == (rsp_ch.gpu_cap != '0))
                        && (rsp_ch.gpu_bw_cap_valid == (rsp_ch.gpu_bw_cap != '0))
                        && (rsp_ch.ddr_cap_valid == (rsp_ch.ddr_cap != '0))))
      else $error("cap valid flag disagrees with cap");

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench of the thermal level frequency capper: table fills, samples, checks
module tb_top;
   import thcap_pkg::*;

   localparam int TBL_DEPTH       = TABLE_DEPTH_DEF;
   localparam int SETTLE_CYCLES   = TABLE_DEPTH_DEF + 8;
   localparam int LONG_HOLD       = 300;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int NUM_PHASES      = 8;
   localparam int TEMP_LOW        = -100000;
   localparam int TEMP_HIGH       = 200000;
   localparam int HYST_HIGH       = 100000;
   localparam int CPU_HIGH        = 4194303;

   // fixed cluster caps in khz, indexed by level (level 0 comes from the registers)
   localparam int unsigned LITTLE_KHZ[5] = '{0, 1401600, 1113600, 998400, 806400};
   localparam int unsigned BIG_KHZ[5]    = '{0, 1804800, 1401600, 1113600, 902400};
   // share of the table maximum in percent, by level then table
   localparam int unsigned FRACTION_PCT[5][3] = '{
      '{100, 100, 100}, '{85, 85, 80}, '{70, 70, 65}, '{55, 55, 50}, '{40, 40, 40}};

   localparam logic [CSR_INDEX_W-1:0] REG_ORDER[7] = '{
      CSR_LEVEL1_THR, CSR_LEVEL2_THR, CSR_LEVEL3_THR, CSR_LEVEL4_THR,
      CSR_HYSTERESIS, CSR_LITTLE_MAX, CSR_BIG_MAX};
   localparam logic [TBL_SEL_W-1:0] REAL_TABLES[3] = '{TBL_GPU, TBL_GPU_BW, TBL_DDR};

   typedef struct {
      logic                        op;
      logic signed [TEMP_W-1:0]    temp;
      logic [TBL_SEL_W-1:0]        sel;
      logic [TBL_IDX_W-1:0]        idx;
      logic [TBL_VAL_W-1:0]        val;
   } req_item_type;

   // shadow of the capper state, predicts level changes and their caps
   class cap_scoreboard;
      int                   thr[4];
      int                   hyst;
      logic [CPU_FREQ_W-1:0] little_max;
      logic [CPU_FREQ_W-1:0] big_max;
      logic [LVL_W-1:0]     last_level;
      logic [TBL_VAL_W-1:0] entries[NUM_TABLES][TBL_DEPTH];
      int                   counts[NUM_TABLES];
      logic [TBL_VAL_W-1:0] peaks[NUM_TABLES];
      result_type           caps_due[$];
      int                   mismatches;
      int                   samples;
      int                   writes;
      int                   changes_seen;

      function new();
         thr[0] = int'(LEVEL1_THR_RST);
         thr[1] = int'(LEVEL2_THR_RST);
         thr[2] = int'(LEVEL3_THR_RST);
         thr[3] = int'(LEVEL4_THR_RST);
         hyst = int'(HYSTERESIS_RST);
         little_max = LITTLE_MAX_RST;
         big_max = BIG_MAX_RST;
         last_level = LVL_UNKNOWN;
         for (int s = 0; s < NUM_TABLES; s++) begin
            counts[s] = 0;
            peaks[s] = '0;
            for (int i = 0; i < TBL_DEPTH; i++) entries[s][i] = '0;
         end
         mismatches = 0;
         samples = 0;
         writes = 0;
         changes_seen = 0;
      endfunction

      function int due();
         return caps_due.size();
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LEVEL1_THR: thr[0] = int'($signed(data[TEMP_W-1:0]));
            CSR_LEVEL2_THR: thr[1] = int'($signed(data[TEMP_W-1:0]));
            CSR_LEVEL3_THR: thr[2] = int'($signed(data[TEMP_W-1:0]));
            CSR_LEVEL4_THR: thr[3] = int'($signed(data[TEMP_W-1:0]));
            CSR_HYSTERESIS: hyst = int'(data[HYST_W-1:0]);
            CSR_LITTLE_MAX: little_max = data[CPU_FREQ_W-1:0];
            CSR_BIG_MAX:    big_max = data[CPU_FREQ_W-1:0];
            default: ;
         endcase
      endfunction

      // quantize against the thresholds, highest first, then apply hysteresis
      function logic [LVL_W-1:0] throttle_level(logic signed [TEMP_W-1:0] temp);
         int                t;
         int                cool;
         logic [LVL_W-1:0]  lvl;
         t = int'(temp);
         if (t >= thr[3]) lvl = LVL_EMERG;
         else if (t >= thr[2]) lvl = LVL_THREE;
         else if (t >= thr[1]) lvl = LVL_TWO;
         else if (t >= thr[0]) lvl = LVL_ONE;
         else lvl = LVL_NONE;
         if (last_level != LVL_UNKNOWN && last_level >= LVL_ONE && last_level <= LVL_EMERG
             && lvl < last_level) begin
            cool = thr[last_level - 1] - hyst;
            if (t > cool) lvl = last_level;
         end
         return lvl;
      endfunction

      // table maximum at level 0, else largest entry not above the share of it, else smallest entry
      function void table_cap(logic [TBL_SEL_W-1:0] sel, logic [LVL_W-1:0] lvl,
                              output logic [TBL_VAL_W-1:0] cap, output logic ok);
         longint unsigned      target;
         logic [TBL_VAL_W-1:0] best;
         int                   n;
         n = counts[sel];
         cap = '0;
         ok = 1'b0;
         if (n == 0) return;
         if (lvl == LVL_NONE) begin
            cap = peaks[sel];
         end else begin
            target = peaks[sel];
            target = target * FRACTION_PCT[lvl][sel] / 100;
            best = '0;
            for (int i = 0; i < n; i++) begin
               if (entries[sel][i] <= target && entries[sel][i] >= best) best = entries[sel][i];
            end
            if (best == '0) begin
               best = entries[sel][0];
               for (int i = 1; i < n; i++) begin
                  if (entries[sel][i] < best) best = entries[sel][i];
               end
            end
            cap = best;
         end
         ok = (cap != '0);
      endfunction

      // update the shadow on an accepted request transfer
      function void note_input(req_item_type it);
         result_type            r;
         logic [LVL_W-1:0]      lvl;
         logic [TBL_VAL_W-1:0]  cap;
         logic                  ok;
         if (it.op == OP_WRITE) begin
            writes++;
            if (it.sel == TBL_NONE) return;
            entries[it.sel][it.idx] = it.val;
            counts[it.sel] = int'(it.idx) + 1;
            if (it.idx == '0 || it.val > peaks[it.sel]) peaks[it.sel] = it.val;
            return;
         end
         samples++;
         lvl = throttle_level(it.temp);
         if (lvl == last_level) return;
         last_level = lvl;
         r.level = lvl;
         r.little_cpu_cap = (lvl == LVL_NONE) ? little_max : CPU_FREQ_W'(LITTLE_KHZ[lvl]);
         r.big_cpu_cap = (lvl == LVL_NONE) ? big_max : CPU_FREQ_W'(BIG_KHZ[lvl]);
         table_cap(TBL_GPU, lvl, cap, ok);
         r.gpu_cap = cap;
         r.gpu_cap_valid = ok;
         table_cap(TBL_GPU_BW, lvl, cap, ok);
         r.gpu_bw_cap = cap;
         r.gpu_bw_cap_valid = ok;
         table_cap(TBL_DDR, lvl, cap, ok);
         r.ddr_cap = cap;
         r.ddr_cap_valid = ok;
         caps_due = {caps_due, r};
      endfunction

      function string show(result_type r);
         return $sformatf("lvl %0d little %0d big %0d gpu %0h/%0b bw %0h/%0b ddr %0h/%0b",
                          r.level, r.little_cpu_cap, r.big_cpu_cap, r.gpu_cap,
                          r.gpu_cap_valid, r.gpu_bw_cap, r.gpu_bw_cap_valid, r.ddr_cap,
                          r.ddr_cap_valid);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("%s", what);
      endfunction

      // compare a result transfer with the oldest prediction
      function void check(result_type got);
         result_type want;
         string      diffs;
         changes_seen++;
         if (caps_due.size() == 0) begin
            flag({"unexpected result: ", show(got)});
            return;
         end
         want = caps_due.pop_front();
         diffs = "";
         if (want.level !== got.level) diffs = {diffs, " level"};
         if (want.little_cpu_cap !== got.little_cpu_cap) diffs = {diffs, " little_cpu_cap"};
         if (want.big_cpu_cap !== got.big_cpu_cap) diffs = {diffs, " big_cpu_cap"};
         if (want.gpu_cap !== got.gpu_cap) diffs = {diffs, " gpu_cap"};
         if (want.gpu_cap_valid !== got.gpu_cap_valid) diffs = {diffs, " gpu_cap_valid"};
         if (want.gpu_bw_cap !== got.gpu_bw_cap) diffs = {diffs, " gpu_bw_cap"};
         if (want.gpu_bw_cap_valid !== got.gpu_bw_cap_valid) diffs = {diffs, " gpu_bw_cap_valid"};
         if (want.ddr_cap !== got.ddr_cap) diffs = {diffs, " ddr_cap"};
         if (want.ddr_cap_valid !== got.ddr_cap_valid) diffs = {diffs, " ddr_cap_valid"};
         if (diffs != "")
            flag($sformatf("mismatch in%s\n  expected %s\n  actual   %s", diffs, show(want),
                           show(got)));
      endfunction
   endclass

   logic          clock;
   logic          reset;
   thcap_req_if   req_ch();
   thcap_rsp_if   rsp_ch();
   thcap_csr_if   csr_ch();

   cap_scoreboard board;
   bit            hold_request;
   int            tx_gap_pct;
   int            rx_gap_pct;
   int            prefix_len[NUM_TABLES];

   thermal_level_freq_capper i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #6000000;
      $display("Some tests failed");
      $finish;
   end

   // result receiver: random stalls and one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.level = rsp_ch.level;
         got.little_cpu_cap = rsp_ch.little_cpu_cap;
         got.big_cpu_cap = rsp_ch.big_cpu_cap;
         got.gpu_cap = rsp_ch.gpu_cap;
         got.gpu_cap_valid = rsp_ch.gpu_cap_valid;
         got.gpu_bw_cap = rsp_ch.gpu_bw_cap;
         got.gpu_bw_cap_valid = rsp_ch.gpu_bw_cap_valid;
         got.ddr_cap = rsp_ch.ddr_cap;
         got.ddr_cap_valid = rsp_ch.ddr_cap_valid;
         board.check(got);
      end
   end

   function automatic int clamp_temp(int t);
      if (t < TEMP_LOW) return TEMP_LOW;
      if (t > TEMP_HIGH) return TEMP_HIGH;
      return t;
   endfunction

   // mostly close to a threshold, where levels change
   function automatic int pick_temp();
      int r;
      int span;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         span = board.hyst + 4000;
         return clamp_temp(board.thr[$urandom_range(0, 3)] - span
                           + int'($urandom_range(0, 2 * span)));
      end
      if (r < 9) return int'($urandom_range(0, TEMP_HIGH - TEMP_LOW)) + TEMP_LOW;
      return $urandom_range(0, 1) ? TEMP_HIGH : TEMP_LOW;
   endfunction

   function automatic logic [TBL_VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2, 3:    return $urandom;
         4, 5:    return $urandom_range(1, 2000);
         default: return $urandom_range(100_000_000, 900_000_000);
      endcase
   endfunction

   // one request transfer, with an optional idle burst ahead of it
   task automatic send_item(req_item_type it);
      if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= it.op;
      req_ch.temperature <= it.temp;
      req_ch.table_select <= it.sel;
      req_ch.table_index <= it.idx;
      req_ch.table_value <= it.val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_input(it);
   endtask

   task automatic send_sample(int t);
      req_item_type it;
      it.op = OP_SAMPLE;
      it.temp = TEMP_W'(t);
      it.sel = TBL_SEL_W'($urandom);
      it.idx = TBL_IDX_W'($urandom);
      it.val = $urandom;
      send_item(it);
   endtask

   // table write; extends the written prefix when idx is its next index, so callers can keep to written entries
   task automatic send_write(logic [TBL_SEL_W-1:0] sel, logic [TBL_IDX_W-1:0] idx,
                             logic [TBL_VAL_W-1:0] val);
      req_item_type it;
      it.op = OP_WRITE;
      it.temp = TEMP_W'(int'($urandom_range(0, TEMP_HIGH - TEMP_LOW)) + TEMP_LOW);
      it.sel = sel;
      it.idx = idx;
      it.val = val;
      if (sel != TBL_NONE && int'(idx) == prefix_len[sel]) prefix_len[sel]++;
      send_item(it);
   endtask

   task automatic random_items(int budget);
      int                   done;
      int                   r;
      int                   last_idx;
      logic [TBL_SEL_W-1:0] sel;
      done = 0;
      while (done < budget) begin
         r = $urandom_range(0, 99);
         sel = REAL_TABLES[$urandom_range(0, 2)];
         if (r < 45) begin
            send_sample(pick_temp());
            done++;
         end else if (r < 55) begin
            // restart a table and fill it in order
            last_idx = $urandom_range(0, 3) == 0 ? TBL_DEPTH - 1 : $urandom_range(0, 5);
            for (int i = 0; i <= last_idx; i++) send_write(sel, TBL_IDX_W'(i), pick_value());
            done += last_idx + 1;
         end else if (r < 92) begin
            last_idx = (prefix_len[sel] < TBL_DEPTH - 1) ? prefix_len[sel] : TBL_DEPTH - 1;
            send_write(sel, TBL_IDX_W'($urandom_range(0, last_idx)), pick_value());
            done++;
         end else begin
            send_write(TBL_NONE, TBL_IDX_W'($urandom), $urandom);
            done++;
         end
      end
   endtask

   // wait until every predicted result has been taken and the block is idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.due() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(int t1, int t2, int t3, int t4, int hy, int little, int big);
      int vals[7];
      vals = '{t1, t2, t3, t4, hy, little, big};
      for (int k = 0; k < $size(REG_ORDER); k++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= REG_ORDER[k];
         csr_ch.data <= CSR_DATA_W'(vals[k]);
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
         board.set_reg(REG_ORDER[k], CSR_DATA_W'(vals[k]));
      end
      csr_ch.valid <= 1'b0;
   endtask

   // thresholds in non-decreasing order at random spacing
   task automatic random_setting();
      int t1;
      int t2;
      int t3;
      int t4;
      t1 = int'($urandom_range(0, 250000)) + TEMP_LOW;
      t2 = clamp_temp(t1 + int'($urandom_range(0, 20000)));
      t3 = clamp_temp(t2 + int'($urandom_range(0, 20000)));
      t4 = clamp_temp(t3 + int'($urandom_range(0, 20000)));
      apply_setting(t1, t2, t3, t4, $urandom_range(0, 8000), $urandom_range(0, CPU_HIGH),
                    $urandom_range(0, CPU_HIGH));
   endtask

   // main sequence
   initial begin
      board = new();
      hold_request = 1'b0;
      tx_gap_pct = 15;
      rx_gap_pct = 10;
      for (int s = 0; s < NUM_TABLES; s++) prefix_len[s] = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_SAMPLE;
      req_ch.temperature = '0;
      req_ch.table_select = TBL_GPU;
      req_ch.table_index = '0;
      req_ch.table_value = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_LEVEL1_THR;
      csr_ch.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: first sample on empty tables, ignored select, zero and full-scale entries
      send_sample(0);
      send_write(TBL_NONE, 4'd7, 32'hDEAD_BEEF);
      send_write(TBL_GPU, 4'd0, 32'hFFFF_FFFF);
      send_write(TBL_GPU, 4'd1, 32'd100);
      send_write(TBL_GPU, 4'd2, 32'd0);
      send_write(TBL_GPU, 4'd3, 32'd3_000_000_000);
      send_write(TBL_GPU_BW, 4'd0, 32'd0);
      send_write(TBL_DDR, 4'd0, 32'd500);
      send_write(TBL_DDR, 4'd1, 32'd800);
      send_write(TBL_DDR, 4'd2, 32'd1000);
      // each threshold exactly, then unchanged level at the top of the range
      send_sample(45000);
      send_sample(50000);
      send_sample(55000);
      send_sample(60000);
      send_sample(TEMP_HIGH);
      // hysteresis: just above and at the cool-down point
      send_sample(57001);
      send_sample(57000);
      send_sample(TEMP_LOW);
      // table restart with stale entries kept below the new count
      send_write(TBL_GPU, 4'd0, 32'd10);
      send_write(TBL_GPU, 4'd3, 32'd20);
      send_sample(44999);
      send_sample(65000);
      send_write(TBL_GPU_BW, 4'd0, 32'd1);
      send_sample(52999);
      send_sample(47000);

      // long result stall while samples keep changing the level
      settle();
      hold_request = 1'b1;
      for (int i = 0; i < 24; i++) send_sample((i % 2) ? 0 : 70000);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            0: apply_setting(45000, 50000, 55000, 60000, 3000, 1843200, 2208000);
            1: apply_setting(TEMP_LOW, 0, 100000, TEMP_HIGH, 0, 0, CPU_HIGH);
            2: apply_setting(TEMP_HIGH, TEMP_HIGH, TEMP_HIGH, TEMP_HIGH, HYST_HIGH, CPU_HIGH,
                             0);
            3: apply_setting(60000, 40000, 50000, 30000, $urandom_range(0, 5000),
                             $urandom_range(0, CPU_HIGH), $urandom_range(0, CPU_HIGH));
            default: random_setting();
         endcase
         tx_gap_pct = (p == 2 || p == NUM_PHASES - 1) ? 0 : 15;
         rx_gap_pct = (p == 4 || p == NUM_PHASES - 1) ? 0 : 10;
         random_items(ITEMS_PER_PHASE);
      end

      settle();
      $display("covered %0d temperature samples, %0d table writes, %0d level changes",
               board.samples, board.writes, board.changes_seen);
      $display("over %0d register settings and one %0d-cycle result stall", NUM_PHASES + 1,
               LONG_HOLD);
      if (board.mismatches == 0 && board.due() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
